@@ sv/sirq_pkg.sv @@
package sirq_pkg;

    localparam int A12_FILTER_TICKS_DEF = 8;
    localparam int IRQ_DELAY_TICKS_DEF  = 12;

    localparam int TICK_W = 4;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;

    localparam logic [ADDR_W-1:0] ADDR_MASK       = 16'hE003;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_LATCH  = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_RELOAD = 16'hC001;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_DIS    = 16'hC002;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_EN     = 16'hC003;
    localparam logic [DATA_W-1:0] LATCH_INVERT    = 8'hFF;

    typedef enum logic [0:0] {
        CMD_CPU_WRITE = 1'b0,
        CMD_PPU_TICK  = 1'b1
    } sirq_cmd_t;

    typedef struct packed {
        sirq_cmd_t         command;
        logic [ADDR_W-1:0] cpu_address;
        logic [DATA_W-1:0] cpu_data;
        logic              ppu_a12;
    } sirq_item_t;

endpackage

@@ sv/sirq_core.sv @@
module sirq_core
    import sirq_pkg::*;
#(
    parameter int A12_FILTER_TICKS = A12_FILTER_TICKS_DEF,
    parameter int IRQ_DELAY_TICKS  = IRQ_DELAY_TICKS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_en,
    input  sirq_item_t item,
    output logic       irq_line_next
);

    logic [DATA_W-1:0] reload_value_reg, reload_value_next;
    logic [DATA_W-1:0] line_counter_reg, line_counter_next;
    logic              reload_pending_reg, reload_pending_next;
    logic              irq_enable_reg, irq_enable_next;
    logic [TICK_W-1:0] a12_low_wait_reg, a12_low_wait_next;
    logic [TICK_W-1:0] irq_delay_reg, irq_delay_next;
    logic              irq_line_reg;

    logic [ADDR_W-1:0] addr_dec;
    logic [TICK_W-1:0] wait_dec;
    logic              clock_counter;

    always_comb begin
        reload_value_next   = reload_value_reg;
        line_counter_next   = line_counter_reg;
        reload_pending_next = reload_pending_reg;
        irq_enable_next     = irq_enable_reg;
        a12_low_wait_next   = a12_low_wait_reg;
        irq_delay_next      = irq_delay_reg;
        irq_line_next       = irq_line_reg;
        addr_dec            = item.cpu_address & ADDR_MASK;
        wait_dec            = a12_low_wait_reg;
        clock_counter       = 1'b0;

        if (item.command == CMD_CPU_WRITE) begin
            if (addr_dec == ADDR_IRQ_LATCH) begin
                reload_value_next = item.cpu_data ^ LATCH_INVERT;
            end else if (addr_dec == ADDR_IRQ_RELOAD) begin
                line_counter_next   = '0;
                reload_pending_next = 1'b1;
            end else if (addr_dec == ADDR_IRQ_DIS) begin
                irq_enable_next = 1'b0;
                irq_line_next   = 1'b0;
            end else if (addr_dec == ADDR_IRQ_EN) begin
                irq_enable_next = 1'b1;
            end
        end else begin
            // delay countdown; line rises when it runs out
            if (irq_delay_reg != '0) begin
                irq_delay_next = irq_delay_reg - TICK_W'(1);
                if (irq_delay_next == '0) begin
                    irq_line_next = 1'b1;
                end
            end
            if (a12_low_wait_reg != '0) begin
                wait_dec = a12_low_wait_reg - TICK_W'(1);
            end
            a12_low_wait_next = wait_dec;
            clock_counter = (wait_dec == '0) && item.ppu_a12;
            if (clock_counter) begin
                if (line_counter_reg == '0 || reload_pending_reg) begin
                    line_counter_next = reload_value_reg;
                end else begin
                    line_counter_next = line_counter_reg - DATA_W'(1);
                end
                if ((line_counter_reg != '0 || reload_pending_reg) &&
                    line_counter_next == '0 && irq_enable_reg) begin
                    irq_delay_next = TICK_W'(IRQ_DELAY_TICKS);
                end
                reload_pending_next = 1'b0;
            end
            if (item.ppu_a12) begin
                a12_low_wait_next = TICK_W'(A12_FILTER_TICKS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_value_reg   <= '0;
            line_counter_reg   <= '0;
            reload_pending_reg <= 1'b0;
            irq_enable_reg     <= 1'b0;
            a12_low_wait_reg   <= '0;
            irq_delay_reg      <= '0;
            irq_line_reg       <= 1'b0;
        end else if (item_en) begin
            reload_value_reg   <= reload_value_next;
            line_counter_reg   <= line_counter_next;
            reload_pending_reg <= reload_pending_next;
            irq_enable_reg     <= irq_enable_next;
            a12_low_wait_reg   <= a12_low_wait_next;
            irq_delay_reg      <= irq_delay_next;
            irq_line_reg       <= irq_line_next;
        end
    end

endmodule

@@ sv/scanline_irq_counter.sv @@
// Scanline IRQ counter: one input beat (CPU write or PPU tick) gives one result beat.
// Latency: the result beat is valid in the cycle after the input beat is accepted.
// Throughput: one beat per cycle; s_ready is low only while a result waits
// and m_ready is low (the result register is the only buffer).
// Reset: synchronous, active low on aresetn; all counter state and the IRQ line
// clear to zero and no result is pending.
module scanline_irq_counter
    import sirq_pkg::*;
#(
    parameter int A12_FILTER_TICKS = A12_FILTER_TICKS_DEF,
    parameter int IRQ_DELAY_TICKS  = IRQ_DELAY_TICKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [ADDR_W-1:0] s_cpu_address,
    input  logic [DATA_W-1:0] s_cpu_data,
    input  logic              s_ppu_a12,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_irq_level
);

    sirq_item_t item;
    logic       in_beat;
    logic       irq_line_next;
    logic       m_valid_reg, m_valid_next;
    logic       m_irq_level_reg;

    // Accept while the result slot is empty or is being drained this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    assign item.command     = sirq_cmd_t'(s_command);
    assign item.cpu_address = s_cpu_address;
    assign item.cpu_data    = s_cpu_data;
    assign item.ppu_a12     = s_ppu_a12;

    // Counter state and its registered update; state moves only on an
    // accepted beat.
    sirq_core #(
        .A12_FILTER_TICKS (A12_FILTER_TICKS),
        .IRQ_DELAY_TICKS  (IRQ_DELAY_TICKS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_en       (in_beat),
        .item          (item),
        .irq_line_next (irq_line_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_beat) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: line level after the accepted item.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            m_irq_level_reg <= irq_line_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_irq_level = m_irq_level_reg;

endmodule

@@ sv/sirq_checker.sv @@
module sirq_checker
    import sirq_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_command,
    input logic [ADDR_W-1:0] s_cpu_address,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_irq_level
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_irq_level))
        else $error("result changed while stalled");

    // every accepted beat yields a result next cycle
    a_beat_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat produced no result");

    // a waiting result blocks the input
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result slot full");

    // IRQ disable write drops the line
    a_disable_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_CPU_WRITE) &&
        ((s_cpu_address & ADDR_MASK) == ADDR_IRQ_DIS) |=> !m_irq_level)
        else $error("IRQ line high after disable write");

endmodule

bind scanline_irq_counter sirq_checker u_sirq_checker (.*);
